// ----- hw/rtl/spcs_pkg.sv -----
// Types, constants and the CRC byte update shared by the shifted-payload CRC-32 sealer.
package spcs_pkg;

  // Message length at which the trailer reports the too-long status.
  localparam int MAX_LEN = 256;
  localparam int CNT_W   = $clog2(MAX_LEN + 1);

  // Reflected CRC-32 constants.
  localparam logic [31:0] CRC_POLY     = 32'hEDB8_8320;
  localparam logic [31:0] CRC_ALL_ONES = 32'hFFFF_FFFF;

  // Reset value of the shift register.
  localparam logic [7:0] SHIFT_RESET = 8'd3;

  // Depth of the result queue; it must hold at least two results.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic {
    OP_SEAL = 1'b0,
    OP_OPEN = 1'b1
  } opcode_e;

  typedef enum logic {
    KIND_DATA    = 1'b0,
    KIND_TRAILER = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_TOO_LONG = 2'd1,
    ST_MISMATCH = 2'd2
  } status_e;

  // One input item as held in the input register.
  typedef struct packed {
    logic        opcode;
    logic [7:0]  data_byte;
    logic        byte_present;
    logic        last;
    logic [31:0] expected_crc;
  } item_t;

  // One result as held in the result queue.
  typedef struct packed {
    logic        kind;
    logic [7:0]  out_byte;
    logic [31:0] crc_value;
    logic [1:0]  status;
    logic        end_of_run;
  } result_t;

  // Reflected CRC-32 update by one byte, eight bit steps unrolled.
  function automatic logic [31:0] crc_feed(logic [31:0] crc, logic [7:0] din);
    logic [31:0] c;
    c = crc ^ {24'd0, din};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ----- hw/rtl/spcs_stream_if.sv -----
// Valid/ready stream interfaces for the input items and the results of the sealer.
interface spcs_item_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [7:0]  data_byte;
  logic        byte_present;
  logic        last;
  logic [31:0] expected_crc;

  modport source (output valid, opcode, data_byte, byte_present, last, expected_crc,
                  input ready);
  modport sink   (input valid, opcode, data_byte, byte_present, last, expected_crc,
                  output ready);
endinterface

interface spcs_result_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  out_byte;
  logic [31:0] crc_value;
  logic [1:0]  status;
  logic        end_of_run;

  modport source (output valid, kind, out_byte, crc_value, status, end_of_run,
                  input ready);
  modport sink   (input valid, kind, out_byte, crc_value, status, end_of_run,
                  output ready);
endinterface

// ----- hw/rtl/shifted_payload_crc32_sealer.sv -----
// Top level of the shifted-payload CRC-32 sealer and opener.
//
//   Channel   Direction  Transfer when   Payload
//   item_i    in         valid & ready   opcode, data_byte, byte_present, last, expected_crc
//   result_o  out        valid & ready   kind, out_byte, crc_value, status, end_of_run
//   cfg       in         cfg_we_i        cfg_wdata_i (shift amount)
//
// An item is captured in the input register, then, once the queue has room, it updates the CRC
// and byte count and pushes zero, one or two results into a four-entry result queue.
// One item per cycle is sustained while each item yields at most one result and results
// are taken; an item with a byte and the end mark yields two results for the single port.
// Reset (rst_ni low, asynchronous) clears the CRC to all ones, the count, the queue
// and sets the shift to 3. The input register holds while the queue lacks two free slots.
module shifted_payload_crc32_sealer
  import spcs_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [7:0]           cfg_wdata_i,
  spcs_item_if.sink            item_i,
  spcs_result_if.source        result_o
);

  logic [7:0]        shift_q;
  logic              stage_valid_q;
  item_t             stage_q;
  logic [31:0]       crc_q, crc_d;
  logic [CNT_W-1:0]  count_q, count_d;
  result_t           queue_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] qcount_q;

  logic              advance;
  logic              in_xfer;
  logic              out_xfer;
  logic [7:0]        enc_byte;
  logic [7:0]        res_byte;
  logic [31:0]       final_crc;
  status_e           trailer_status;
  result_t           data_res, trailer_res;
  result_t           push0, push1;
  logic [1:0]        n_push;
  logic [QPTR_W-1:0] wr_ptr_p1;

  // Shift register, written by the configuration port.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q <= SHIFT_RESET;
    end else if (cfg_we_i) begin
      shift_q <= cfg_wdata_i;
    end
  end

  // The staged item moves on once the queue has room for both of its possible results.
  assign advance      = stage_valid_q && (qcount_q <= QCNT_W'(QUEUE_DEPTH - 2));
  assign item_i.ready = !stage_valid_q || advance;
  assign in_xfer      = item_i.valid && item_i.ready;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_valid_q <= 1'b0;
    end else if (item_i.ready) begin
      stage_valid_q <= item_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      stage_q.opcode       <= item_i.opcode;
      stage_q.data_byte    <= item_i.data_byte;
      stage_q.byte_present <= item_i.byte_present;
      stage_q.last         <= item_i.last;
      stage_q.expected_crc <= item_i.expected_crc;
    end
  end

  // Byte transform and CRC over the encoded byte.
  always_comb begin
    if (opcode_e'(stage_q.opcode) == OP_SEAL) begin
      enc_byte = stage_q.data_byte + shift_q;
      res_byte = enc_byte;
    end else begin
      enc_byte = stage_q.data_byte;
      res_byte = stage_q.data_byte - shift_q;
    end

    crc_d   = crc_q;
    count_d = count_q;
    if (stage_q.byte_present) begin
      crc_d = crc_feed(crc_q, enc_byte);
      if (count_q < CNT_W'(MAX_LEN)) begin
        count_d = count_q + CNT_W'(1);
      end
    end

    final_crc = ~crc_d;
    if (count_d >= CNT_W'(MAX_LEN)) begin
      trailer_status = ST_TOO_LONG;
    end else if (opcode_e'(stage_q.opcode) == OP_OPEN && final_crc != stage_q.expected_crc) begin
      trailer_status = ST_MISMATCH;
    end else begin
      trailer_status = ST_OK;
    end
  end

  // Results of the staged item: data byte first, then the trailer.
  always_comb begin
    data_res            = '0;
    data_res.kind       = KIND_DATA;
    data_res.out_byte   = res_byte;

    trailer_res            = '0;
    trailer_res.kind       = KIND_TRAILER;
    trailer_res.crc_value  = final_crc;
    trailer_res.status     = trailer_status;
    trailer_res.end_of_run = 1'b1;

    push0 = stage_q.byte_present ? data_res : trailer_res;
    push1 = trailer_res;
    if (!advance) begin
      n_push = 2'd0;
    end else begin
      n_push = {1'b0, stage_q.byte_present} + {1'b0, stage_q.last};
    end
  end

  // Message state, cleared after each trailer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q   <= CRC_ALL_ONES;
      count_q <= '0;
    end else if (advance) begin
      if (stage_q.last) begin
        crc_q   <= CRC_ALL_ONES;
        count_q <= '0;
      end else begin
        crc_q   <= crc_d;
        count_q <= count_d;
      end
    end
  end

  // Result queue pointers and fill level.
  assign out_xfer  = result_o.valid && result_o.ready;
  assign wr_ptr_p1 = wr_ptr_q + QPTR_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      qcount_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + QPTR_W'(n_push);
      if (out_xfer) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
      qcount_q <= qcount_q + QCNT_W'(n_push) - QCNT_W'(out_xfer);
    end
  end

  // Result queue storage.
  always_ff @(posedge clk_i) begin
    if (n_push != 2'd0) begin
      queue_q[wr_ptr_q] <= push0;
    end
    if (n_push == 2'd2) begin
      queue_q[wr_ptr_p1] <= push1;
    end
  end

  // Output port driven from the queue head.
  assign result_o.valid      = (qcount_q != '0);
  assign result_o.kind       = queue_q[rd_ptr_q].kind;
  assign result_o.out_byte   = queue_q[rd_ptr_q].out_byte;
  assign result_o.crc_value  = queue_q[rd_ptr_q].crc_value;
  assign result_o.status     = queue_q[rd_ptr_q].status;
  assign result_o.end_of_run = queue_q[rd_ptr_q].end_of_run;

  // The queue never overfills.
  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    qcount_q <= QCNT_W'(QUEUE_DEPTH))
    else $error("result queue overfilled");

  // A trailer leaves the CRC preset for the next message.
  a_crc_rearm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && stage_q.last) |=> (crc_q == CRC_ALL_ONES && count_q == '0))
    else $error("message state not cleared after trailer");

  // The byte count saturates at the length limit.
  a_count_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_LEN))
    else $error("byte count beyond limit");

  // Each pushed trailer carries the end-of-run flag and a zero byte.
  a_trailer_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && stage_q.last) |-> (trailer_res.end_of_run && trailer_res.out_byte == 8'd0))
    else $error("malformed trailer");

endmodule
